@@ hdl/ppc_pkg.sv @@
// shared types and constants of the point projection and cull block
package ppc_pkg;

    localparam int COORD_W   = 21;
    localparam int COEF_W    = 16;
    localparam int PIX_W     = 16;
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int CAM_W     = ACC_W - 14;
    localparam int NUM_W     = PIX_W + 1 + CAM_W;
    localparam int MAG_W     = NUM_W - 1;
    localparam int QUO_W     = PIX_W + 1;
    localparam int DIV_STAGES = QUO_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X      = 3'd0,
        REG_ROT_Y      = 3'd1,
        REG_ROT_Z      = 3'd2,
        REG_TRANS      = 3'd3,
        REG_FOCAL      = 3'd4,
        REG_PRINCIPAL  = 3'd5,
        REG_DEPTH      = 3'd6,
        REG_BOUNDS     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_VISIBLE = 2'd0,
        ST_NEAR    = 2'd1,
        ST_FAR     = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    localparam logic [47:0] ROT_X_RST  = 48'd16384;
    localparam logic [47:0] ROT_Y_RST  = 48'd1073741824;
    localparam logic [47:0] ROT_Z_RST  = 48'd70368744177664;
    localparam logic [62:0] TRANS_RST  = 63'd0;
    localparam logic [31:0] FOCAL_RST  = 32'd524296000;
    localparam logic [31:0] PRINC_RST  = 32'd251663360;
    localparam logic [41:0] DEPTH_RST  = 42'd214748364902;
    localparam logic [63:0] BOUNDS_RST = 64'd2161727821808926720;

endpackage

@@ hdl/ppc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module ppc_div (
    input  logic                          i_clk,
    input  logic [ppc_pkg::COORD_W-1:0]   i_rem,
    input  logic [ppc_pkg::QUO_W-1:0]     i_low,
    input  logic [ppc_pkg::COORD_W-1:0]   i_den,
    output logic [ppc_pkg::QUO_W-1:0]     o_quo
);

    localparam int N = ppc_pkg::DIV_STAGES;
    localparam int W = ppc_pkg::COORD_W;
    localparam int Q = ppc_pkg::QUO_W;

    logic [W-1:0] r_rem [N];
    logic [Q-1:0] r_low [N];
    logic [Q-1:0] r_quo [N];
    logic [W-1:0] r_den [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [W-1:0] rem_in;
        logic [Q-1:0] low_in;
        logic [Q-1:0] quo_in;
        logic [W-1:0] den_in;
        logic [W:0]   trial;
        logic         ge;

        if (s == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        assign trial = {rem_in, low_in[Q-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
            r_low[s] <= {low_in[Q-2:0], 1'b0};
            r_quo[s] <= {quo_in[Q-2:0], ge};
            r_den[s] <= den_in;
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

@@ hdl/pinhole_point_projection_cull.sv @@
// top level: world point to camera frame, depth cull, pinhole projection, image cull
//
// usage: a point is taken on every clock edge where start is high; busy is
// always low, so a new point may follow in every cycle.
// configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
// register index and data; write only while no point is in flight.
// each point gives exactly one result: o_valid is high for one cycle with
// status, pixel position and saturated camera depth.
// throughput is one point per cycle; the pipeline holds the rotation multiply
// and sum (2 stages), the depth test and focal multiply (1), magnitude and
// range check (1), the 17-stage divider (one quotient bit per stage) and the
// final offset and bounds stage (1).
// the receiver cannot stall; results are never held back.
// reset (synchronous, active low) restores the default camera and clears
// all pipeline valid bits; points in flight are dropped.
module pinhole_point_projection_cull (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ppc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ppc_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [ppc_pkg::COORD_W-1:0] i_point_z,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [ppc_pkg::PIX_W-1:0]       o_u_pixel,
    output logic [ppc_pkg::PIX_W-1:0]       o_v_pixel,
    output logic signed [ppc_pkg::COORD_W-1:0] o_camera_depth
);

    localparam int CW = ppc_pkg::COORD_W;
    localparam int PW = ppc_pkg::PROD_W;
    localparam int AW = ppc_pkg::ACC_W;
    localparam int MW = ppc_pkg::CAM_W;
    localparam int NW = ppc_pkg::NUM_W;
    localparam int GW = ppc_pkg::MAG_W;
    localparam int QW = ppc_pkg::QUO_W;
    localparam int XW = ppc_pkg::PIX_W;
    localparam int DN = ppc_pkg::DIV_STAGES;

    // configuration registers
    logic [47:0] r_rot [3];
    logic [62:0] r_trans;
    logic [31:0] r_focal;
    logic [31:0] r_princ;
    logic [41:0] r_depth;
    logic [63:0] r_bounds;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ppc_pkg::ROT_X_RST;
            r_rot[1] <= ppc_pkg::ROT_Y_RST;
            r_rot[2] <= ppc_pkg::ROT_Z_RST;
            r_trans  <= ppc_pkg::TRANS_RST;
            r_focal  <= ppc_pkg::FOCAL_RST;
            r_princ  <= ppc_pkg::PRINC_RST;
            r_depth  <= ppc_pkg::DEPTH_RST;
            r_bounds <= ppc_pkg::BOUNDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ppc_pkg::t_reg_idx'(i_cfg_index))
                ppc_pkg::REG_ROT_X:     r_rot[0] <= i_cfg_data[47:0];
                ppc_pkg::REG_ROT_Y:     r_rot[1] <= i_cfg_data[47:0];
                ppc_pkg::REG_ROT_Z:     r_rot[2] <= i_cfg_data[47:0];
                ppc_pkg::REG_TRANS:     r_trans  <= i_cfg_data[62:0];
                ppc_pkg::REG_FOCAL:     r_focal  <= i_cfg_data[31:0];
                ppc_pkg::REG_PRINCIPAL: r_princ  <= i_cfg_data[31:0];
                ppc_pkg::REG_DEPTH:     r_depth  <= i_cfg_data[41:0];
                ppc_pkg::REG_BOUNDS:    r_bounds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: nine rotation products
    logic              r_v1;
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [CW-1:0] pt [3];

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= PW'($signed(r_rot[r][16*c +: 16]) * pt[c]);
            end
        end
    end

    // stage 2: sum with translation, floor to q.10
    logic              r_v2;
    logic signed [MW-1:0] r_cam [3];
    logic signed [AW-1:0] acc [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = AW'(r_prod[r][0]) + AW'(r_prod[r][1]) + AW'(r_prod[r][2])
                   + (AW'($signed(r_trans[CW*r +: CW])) <<< 14);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_cam[r] <= MW'(acc[r] >>> 14);
        end
    end

    // stage 3: depth tests, saturation, focal products
    logic                 r_v3;
    logic [1:0]           r_st3;
    logic signed [CW-1:0] r_dep3;
    logic signed [NW-1:0] r_nu;
    logic signed [NW-1:0] r_nv;
    logic [CW-1:0]        r_z3;
    logic signed [MW-1:0] near_s;
    logic signed [MW-1:0] far_s;
    logic [1:0]           n_st3;
    logic signed [CW-1:0] n_dep3;

    assign near_s = $signed(MW'(r_depth[20:0]));
    assign far_s  = $signed(MW'(r_depth[41:21]));

    always_comb begin
        if (r_cam[2] < near_s || r_cam[2] <= 0) begin
            n_st3 = ppc_pkg::ST_NEAR;
        end else if (r_cam[2] > far_s) begin
            n_st3 = ppc_pkg::ST_FAR;
        end else begin
            n_st3 = ppc_pkg::ST_VISIBLE;
        end
        if (r_cam[2] > $signed(MW'({1'b0, {(CW-1){1'b1}}}))) begin
            n_dep3 = {1'b0, {(CW-1){1'b1}}};
        end else if (r_cam[2] < -$signed(MW'({1'b1, {(CW-1){1'b0}}}))) begin
            n_dep3 = {1'b1, {(CW-1){1'b0}}};
        end else begin
            n_dep3 = CW'(r_cam[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st3  <= n_st3;
        r_dep3 <= n_dep3;
        r_nu   <= NW'($signed({1'b0, r_focal[15:0]}) * r_cam[0]);
        r_nv   <= NW'($signed({1'b0, r_focal[31:16]}) * r_cam[1]);
        r_z3   <= r_cam[2][CW-1:0];
    end

    // stage 4: magnitudes and quotient range check
    logic                 r_v4;
    logic [1:0]           r_st4;
    logic signed [CW-1:0] r_dep4;
    logic                 r_su4;
    logic                 r_sv4;
    logic                 r_ou4;
    logic                 r_ov4;
    logic [GW-1:0]        r_mu4;
    logic [GW-1:0]        r_mv4;
    logic [CW-1:0]        r_z4;
    logic [GW-1:0]        mag_u;
    logic [GW-1:0]        mag_v;

    assign mag_u = GW'(r_nu[NW-1] ? -r_nu : r_nu);
    assign mag_v = GW'(r_nv[NW-1] ? -r_nv : r_nv);

    always_ff @(posedge i_clk) begin
        r_st4  <= r_st3;
        r_dep4 <= r_dep3;
        r_su4  <= r_nu[NW-1];
        r_sv4  <= r_nv[NW-1];
        // quotient of 2^17 or more can never land inside the image
        r_ou4  <= mag_u[GW-1:QW] >= (GW-QW)'(r_z3);
        r_ov4  <= mag_v[GW-1:QW] >= (GW-QW)'(r_z3);
        r_mu4  <= mag_u;
        r_mv4  <= mag_v;
        r_z4   <= (r_z3 == '0) ? CW'(1) : r_z3;
    end

    // divider stages
    logic [QW-1:0] quo_u;
    logic [QW-1:0] quo_v;

    ppc_div u_div_u (
        .i_clk (i_clk),
        .i_rem (r_mu4[QW +: CW]),
        .i_low (r_mu4[QW-1:0]),
        .i_den (r_z4),
        .o_quo (quo_u)
    );

    ppc_div u_div_v (
        .i_clk (i_clk),
        .i_rem (r_mv4[QW +: CW]),
        .i_low (r_mv4[QW-1:0]),
        .i_den (r_z4),
        .o_quo (quo_v)
    );

    // side data travels alongside the divider
    logic                 r_dv  [DN];
    logic [1:0]           r_dst [DN];
    logic signed [CW-1:0] r_ddep[DN];
    logic [3:0]           r_dflg[DN];

    always_ff @(posedge i_clk) begin
        r_dst[0]  <= r_st4;
        r_ddep[0] <= r_dep4;
        r_dflg[0] <= {r_su4, r_sv4, r_ou4, r_ov4};
        for (int i = 1; i < DN; i++) begin
            r_dst[i]  <= r_dst[i-1];
            r_ddep[i] <= r_ddep[i-1];
            r_dflg[i] <= r_dflg[i-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int i = 0; i < DN; i++) begin
                r_dv[i] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_dv[0] <= r_v4;
            for (int i = 1; i < DN; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            o_valid <= r_dv[DN-1];
        end
    end

    // final stage: sign, principal point, bounds
    logic signed [QW+1:0] u_val;
    logic signed [QW+1:0] v_val;
    logic                 in_image;
    logic [3:0]           flg;

    assign flg   = r_dflg[DN-1];
    assign u_val = (flg[3] ? -$signed((QW+2)'(quo_u)) : $signed((QW+2)'(quo_u)))
                 + $signed((QW+2)'(r_princ[15:0]));
    assign v_val = (flg[2] ? -$signed((QW+2)'(quo_v)) : $signed((QW+2)'(quo_v)))
                 + $signed((QW+2)'(r_princ[31:16]));
    assign in_image = !flg[1] && !flg[0]
                 && u_val >= $signed((QW+2)'(r_bounds[15:0]))
                 && u_val <= $signed((QW+2)'(r_bounds[31:16]))
                 && v_val >= $signed((QW+2)'(r_bounds[47:32]))
                 && v_val <= $signed((QW+2)'(r_bounds[63:48]));

    always_ff @(posedge i_clk) begin
        o_camera_depth <= r_ddep[DN-1];
        o_u_pixel      <= '0;
        o_v_pixel      <= '0;
        if (r_dst[DN-1] != ppc_pkg::ST_VISIBLE) begin
            o_status <= r_dst[DN-1];
        end else if (!in_image) begin
            o_status <= ppc_pkg::ST_OUTSIDE;
        end else begin
            o_status  <= ppc_pkg::ST_VISIBLE;
            o_u_pixel <= u_val[XW-1:0];
            o_v_pixel <= v_val[XW-1:0];
        end
    end

`ifndef SYNTH
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |=> r_dv[0])
        else $error("valid lost entering divider");
    a_culled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ppc_pkg::ST_VISIBLE |-> o_u_pixel == '0 && o_v_pixel == '0)
        else $error("culled point with nonzero pixel");
    a_visible_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ppc_pkg::ST_VISIBLE |-> o_camera_depth > 0)
        else $error("visible point with nonpositive depth");
    a_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_st4 == ppc_pkg::ST_VISIBLE |-> r_z4 != '0)
        else $error("zero divisor on visible point");
`endif

endmodule
